>>> hdl/pn3_pkg.sv
// ----------------------------------------------------------------------------
// pn3_pkg
// Shared constants, types and the permutation table for the 3D noise block.
// ----------------------------------------------------------------------------
`default_nettype none
package pn3_pkg;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned OUT_W     = 18;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PERM_SIZE_DEF = 256;
  localparam int unsigned Q_W       = 16;
  // Dot products and blended values live in [-2.0, 2.0] plus margin: Q4.16 signed.
  localparam int unsigned VAL_W     = 20;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [Q_W-1:0] frac_t;
  typedef logic [7:0] cell_t;

  function automatic logic [7:0] perm_rom(input logic [7:0] idx);
    logic [7:0] rom [256];
    rom = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
      8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
      8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
      8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
      8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
      8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
      8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
      8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
      8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
      8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
      8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,
      8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,
      8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
      8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
      8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
      8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,
      8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
      8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
      8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
      8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180};
    return rom[idx];
  endfunction

  // Gradient dot product for one corner, selected by the low four hash bits.
  function automatic val_t corner_grad(input logic [7:0] hash, input val_t dx,
                                       input val_t dy, input val_t dz);
    logic [3:0] h;
    val_t u;
    val_t v;
    val_t su;
    val_t sv;
    h  = hash[3:0];
    u  = (h < 4'd8) ? dx : dy;
    v  = (h < 4'd4) ? dy : (((h == 4'd12) || (h == 4'd14)) ? dx : dz);
    su = h[0] ? -u : u;
    sv = h[1] ? -v : v;
    return su + sv;
  endfunction
endpackage
`default_nettype wire

>>> hdl/pn3_if.sv
// ----------------------------------------------------------------------------
// pn3_in_if / pn3_out_if
// Valid/ready channels for the noise block: coordinate words in, noise out.
// ----------------------------------------------------------------------------
`default_nettype none
interface pn3_in_if
  import pn3_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;
  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface pn3_out_if
  import pn3_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface
`default_nettype wire

>>> hdl/perlin_noise_3d.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d
// Improved 3D gradient noise, pipelined, one point per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The in channel takes one word per cycle holding coord_x, coord_y, coord_z
//   in unsigned fixed point with FRAC_BITS fraction bits; the integer part
//   wraps modulo 256. The out channel returns one noise_value word per input
//   word, signed Q2.16, saturated, in input order.
//   The pipeline has 8 register stages: three hash lookups (with the three
//   fade stages alongside), one corner dot product stage, three blend levels
//   and a saturating output register. Throughput is one word per cycle
//   while the output word is not held by the receiver.
//   When the receiver holds a valid output word, the whole pipeline holds and
//   in_ch.ready drops; no word is lost or repeated. Reset clears only the
//   valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module perlin_noise_3d
  import pn3_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned PERM_SIZE = PERM_SIZE_DEF
)(
  input  wire logic clk,
  input  wire logic rst_n,
  pn3_in_if.sink    in_ch,
  pn3_out_if.source out_ch
);
  localparam int unsigned DEPTH = 8;
  localparam int unsigned PMASK = PERM_SIZE - 1;

  logic [DEPTH-1:0] vld_r;
  logic             en;
  // Pipeline advances unless the output word is held by the receiver.
  assign en           = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
    end
  end

  // Split coordinates into cell and 16-bit fraction.
  cell_t cx, cy, cz;
  frac_t fx, fy, fz;
  function automatic frac_t to_frac(input logic [COORD_W-1:0] c);
    logic [COORD_W+Q_W-1:0] wide;
    wide = (COORD_W+Q_W)'(c) << Q_W;
    return wide[FRAC_BITS +: Q_W];
  endfunction
  always_comb begin
    cx = 8'(in_ch.coord_x >> FRAC_BITS);
    cy = 8'(in_ch.coord_y >> FRAC_BITS);
    cz = 8'(in_ch.coord_z >> FRAC_BITS);
    fx = to_frac(in_ch.coord_x);
    fy = to_frac(in_ch.coord_y);
    fz = to_frac(in_ch.coord_z);
  end

  function automatic logic [7:0] rom_at(input logic [7:0] i);
    return perm_rom(i & 8'(PMASK));
  endfunction

  // Fractions travel alongside the hash stages.
  frac_t fx_r [3];
  frac_t fy_r [3];
  frac_t fz_r [3];
  cell_t cy1_r, cz1_r;
  logic [7:0] a_r, b_r;
  logic [7:0] haa_r, hab_r, hba_r, hbb_r;
  logic [7:0] g_r [8];

  // Hash stage one: first permutation lookup.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= rom_at(cx);
      b_r   <= rom_at(cx + 8'd1);
      cy1_r <= cy;
      cz1_r <= cz;
      fx_r[0] <= fx; fy_r[0] <= fy; fz_r[0] <= fz;
    end
  end

  // Hash stage two: row hashes plus z cell.
  logic [7:0] ha, hb;
  assign ha = a_r + cy1_r;
  assign hb = b_r + cy1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      haa_r <= rom_at(ha) + cz1_r;
      hab_r <= rom_at(ha + 8'd1) + cz1_r;
      hba_r <= rom_at(hb) + cz1_r;
      hbb_r <= rom_at(hb + 8'd1) + cz1_r;
      fx_r[1] <= fx_r[0]; fy_r[1] <= fy_r[0]; fz_r[1] <= fz_r[0];
    end
  end

  // Hash stage three: corner gradient codes.
  always_ff @(posedge clk) begin
    if (en) begin
      g_r[0] <= rom_at(haa_r);
      g_r[1] <= rom_at(hba_r);
      g_r[2] <= rom_at(hab_r);
      g_r[3] <= rom_at(hbb_r);
      g_r[4] <= rom_at(haa_r + 8'd1);
      g_r[5] <= rom_at(hba_r + 8'd1);
      g_r[6] <= rom_at(hab_r + 8'd1);
      g_r[7] <= rom_at(hbb_r + 8'd1);
      fx_r[2] <= fx_r[1]; fy_r[2] <= fy_r[1]; fz_r[2] <= fz_r[1];
    end
  end

  // Fade curves start at input and finish with the hashes.
  frac_t wx, wy, wz;
  pn3_fade u_fade_x (.clk(clk), .en(en), .t_in(fx), .fade_out(wx));
  pn3_fade u_fade_y (.clk(clk), .en(en), .t_in(fy), .fade_out(wy));
  pn3_fade u_fade_z (.clk(clk), .en(en), .t_in(fz), .fade_out(wz));

  // Corner dot products, registered.
  val_t nx, ny, nz, px, py, pz;
  assign nx = val_t'({1'b0, fx_r[2]});
  assign ny = val_t'({1'b0, fy_r[2]});
  assign nz = val_t'({1'b0, fz_r[2]});
  assign px = nx - val_t'(32'sd65536);
  assign py = ny - val_t'(32'sd65536);
  assign pz = nz - val_t'(32'sd65536);
  val_t d_r [8];
  // Fade y and z wait until their blend level is reached.
  frac_t wy_r, wy2_r, wz_r, wz2_r, wz3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= corner_grad(g_r[0], nx, ny, nz);
      d_r[1] <= corner_grad(g_r[1], px, ny, nz);
      d_r[2] <= corner_grad(g_r[2], nx, py, nz);
      d_r[3] <= corner_grad(g_r[3], px, py, nz);
      d_r[4] <= corner_grad(g_r[4], nx, ny, pz);
      d_r[5] <= corner_grad(g_r[5], px, ny, pz);
      d_r[6] <= corner_grad(g_r[6], nx, py, pz);
      d_r[7] <= corner_grad(g_r[7], px, py, pz);
      wy_r  <= wy;
      wy2_r <= wy_r;
      wz_r  <= wz;
      wz2_r <= wz_r;
      wz3_r <= wz2_r;
    end
  end

  // Fade x lines up with the dot products one stage later.
  frac_t wx_r;
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= wx;
    end
  end

  // Blend tree: x, then y, then z.
  val_t l1 [4];
  val_t l2 [2];
  val_t l3;
  pn3_lerp u_lx0 (.clk(clk), .en(en), .w(wx_r), .a(d_r[0]), .b(d_r[1]), .y(l1[0]));
  pn3_lerp u_lx1 (.clk(clk), .en(en), .w(wx_r), .a(d_r[2]), .b(d_r[3]), .y(l1[1]));
  pn3_lerp u_lx2 (.clk(clk), .en(en), .w(wx_r), .a(d_r[4]), .b(d_r[5]), .y(l1[2]));
  pn3_lerp u_lx3 (.clk(clk), .en(en), .w(wx_r), .a(d_r[6]), .b(d_r[7]), .y(l1[3]));
  pn3_lerp u_ly0 (.clk(clk), .en(en), .w(wy2_r), .a(l1[0]), .b(l1[1]), .y(l2[0]));
  pn3_lerp u_ly1 (.clk(clk), .en(en), .w(wy2_r), .a(l1[2]), .b(l1[3]), .y(l2[1]));
  pn3_lerp u_lz  (.clk(clk), .en(en), .w(wz3_r), .a(l2[0]), .b(l2[1]), .y(l3));

  // Saturate into the output word.
  logic signed [OUT_W-1:0] out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (l3 > val_t'(32'sd131071)) begin
        out_r <= OUT_W'(131071);
      end else if (l3 < val_t'(-32'sd131072)) begin
        out_r <= OUT_W'(-131072);
      end else begin
        out_r <= OUT_W'(l3);
      end
    end
  end

  assign out_ch.valid       = vld_r[DEPTH-1];
  assign out_ch.noise_value = out_r;
endmodule
`default_nettype wire

>>> hdl/pn3_fade.sv
// ----------------------------------------------------------------------------
// pn3_fade
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 on a 16-bit fraction.
// ----------------------------------------------------------------------------
`default_nettype none
module pn3_fade
  import pn3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  en,
  input  wire frac_t t_in,
  output frac_t      fade_out
);
  frac_t       t1_r;
  frac_t       sq_r;
  frac_t       cube_r;
  logic [19:0] poly_r;
  logic [31:0] prod;
  logic [31:0] sq_full;
  logic [31:0] cube_full;
  logic [19:0] poly_nxt;

  assign sq_full   = 32'(t_in) * 32'(t_in);
  assign cube_full = 32'(sq_r) * 32'(t1_r);
  // Polynomial 6t^2 - 15t + 10 is always positive and below 2^20.
  assign poly_nxt  = 20'(21'(sq_r) * 21'd6 + 21'd655360 - 21'(t1_r) * 21'd15);
  // The fade never reaches one, so the weighted product stays below 2^32.
  assign prod      = 32'(cube_r) * 32'(poly_r);

  // Stage one squares, stage two cubes, stage three weights.
  always_ff @(posedge clk) begin
    if (en) begin
      t1_r     <= t_in;
      sq_r     <= sq_full[31:16];
      cube_r   <= cube_full[31:16];
      poly_r   <= poly_nxt;
      fade_out <= prod[31:16];
    end
  end
endmodule
`default_nettype wire

>>> hdl/pn3_lerp.sv
// ----------------------------------------------------------------------------
// pn3_lerp
// Registered blend a + floor(w * (b - a) / 2^16).
// ----------------------------------------------------------------------------
`default_nettype none
module pn3_lerp
  import pn3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  en,
  input  wire frac_t w,
  input  wire val_t  a,
  input  wire val_t  b,
  output val_t       y
);
  logic signed [VAL_W:0]      diff;
  logic signed [VAL_W+17:0]   prod;
  assign diff = (VAL_W+1)'(b) - (VAL_W+1)'(a);
  assign prod = (VAL_W+18)'(diff) * $signed({2'b00, w});

  // Arithmetic shift gives the floor of the scaled difference.
  always_ff @(posedge clk) begin
    if (en) begin
      y <= a + VAL_W'(prod >>> Q_W);
    end
  end
endmodule
`default_nettype wire
